### design/saturating_integer_accumulator_core_macros.svh
`ifndef SATURATING_INTEGER_ACCUMULATOR_CORE_MACROS_SVH
`define SATURATING_INTEGER_ACCUMULATOR_CORE_MACROS_SVH

// same-cycle implication
`define SIA_ASSERT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/sia_pkg.sv
package sia_pkg;

	localparam int DATA_W = 32;
	localparam int WIDE_W = 2 * DATA_W;
	localparam int ACT_W  = 3;
	localparam int DIV_STEPS = DATA_W;
	localparam int CNT_W  = $clog2(DIV_STEPS);

	localparam logic [ACT_W-1:0] ACT_SET  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ADD  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_MUL  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DIV  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_FRAC = 3'd4;

	localparam logic signed [DATA_W-1:0] SAT_HIGH = 32'sd1000000000;
	localparam logic signed [DATA_W-1:0] SAT_LOW  = -32'sd1000000000;
	localparam logic        [DATA_W-1:0] SAT_MAG  = 32'd1000000000;
	localparam logic signed [DATA_W-1:0] INT_MIN  = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] MINUS_ONE = -32'sd1;

	typedef struct packed {
		logic              start;
		logic [WIDE_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic              ovf;
		logic [DATA_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] x);
		return x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
	endfunction

	function automatic logic [WIDE_W-1:0] abs64(input logic signed [WIDE_W-1:0] x);
		return x[WIDE_W-1] ? WIDE_W'(-x) : WIDE_W'(x);
	endfunction

	function automatic logic signed [DATA_W-1:0] sat64(input logic signed [WIDE_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > WIDE_W'(SAT_HIGH))
			r = SAT_HIGH;
		else if (v < WIDE_W'(SAT_LOW))
			r = SAT_LOW;
		else
			r = DATA_W'(v);
		return r;
	endfunction

endpackage

### design/sia_div.sv
module sia_div (
	input  logic              clk,
	input  logic              arst_n,
	input  sia_pkg::div_req_t req,
	output sia_pkg::div_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic                          ovf_q;
	logic [sia_pkg::CNT_W-1:0]     cnt_q;
	logic [sia_pkg::DATA_W-1:0]    rem_q;
	logic [sia_pkg::DATA_W-1:0]    quo_q;
	logic [sia_pkg::DATA_W-1:0]    dsr_q;

	logic [sia_pkg::DATA_W:0]      shifted;
	logic [sia_pkg::DATA_W:0]      diff;
	logic                          ge;

	// one restoring step: shift in next dividend bit, trial subtract
	assign shifted = {rem_q, quo_q[sia_pkg::DATA_W-1]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (req.start) begin
				dsr_q <= req.divisor;
				// high half >= divisor: quotient needs more than 32 bits
				if (req.dividend[sia_pkg::WIDE_W-1:sia_pkg::DATA_W] >= req.divisor) begin
					ovf_q  <= 1'b1;
					done_q <= 1'b1;
					busy_q <= 1'b0;
				end else begin
					ovf_q  <= 1'b0;
					done_q <= 1'b0;
					rem_q  <= req.dividend[sia_pkg::WIDE_W-1:sia_pkg::DATA_W];
					quo_q  <= req.dividend[sia_pkg::DATA_W-1:0];
					cnt_q  <= sia_pkg::CNT_W'(sia_pkg::DIV_STEPS - 1);
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				rem_q  <= ge ? diff[sia_pkg::DATA_W-1:0] : shifted[sia_pkg::DATA_W-1:0];
				quo_q  <= {quo_q[sia_pkg::DATA_W-2:0], ge};
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == '0);
				if (cnt_q == '0)
					busy_q <= 1'b0;
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.ovf      = ovf_q;
	assign rsp.quotient = quo_q;

endmodule

### design/saturating_integer_accumulator_core.sv
// Channel  Handshake              Payload
// in       in_valid / in_ready    action, operand, denominator
// out      out_valid / out_ready  result_value
//
// Set, add, unused codes, divide by zero or overflow: idle, then output state; multiply:
// product state first. Divide uses a 32-step restoring divider (one quotient bit per
// cycle); frac computes the product, then divides unless the denominator is zero.
// One item at a time; in_ready is low from transfer until the result sits in
// the output register. A stalled output holds the next result back.
// Reset clears the accumulator to zero.
`include "saturating_integer_accumulator_core_macros.svh"

module saturating_integer_accumulator_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sia_pkg::ACT_W-1:0]           action,
	input  logic signed [sia_pkg::DATA_W-1:0]   operand,
	input  logic signed [sia_pkg::DATA_W-1:0]   denominator,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [sia_pkg::DATA_W-1:0]   result_value
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PROD = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_OUT  = 3'd3;

	logic [2:0]                          state_q;
	logic [sia_pkg::ACT_W-1:0]           act_q;
	logic signed [sia_pkg::DATA_W-1:0]   den_q;
	logic signed [sia_pkg::WIDE_W-1:0]   prod_q;
	logic                                neg_q;
	logic [VALUE_WIDTH-1:0]              acc_q;
	logic                                out_valid_q;
	logic signed [sia_pkg::DATA_W-1:0]   out_q;

	logic signed [sia_pkg::DATA_W-1:0]   acc_s;
	logic signed [sia_pkg::WIDE_W-1:0]   sum_w;
	logic signed [sia_pkg::DATA_W-1:0]   zero_div;
	logic signed [sia_pkg::DATA_W-1:0]   quo_s;
	logic                                div_special;
	sia_pkg::div_req_t                   div_req;
	sia_pkg::div_rsp_t                   div_rsp;

	// all results fit 32 bits; upper accumulator bits are sign extension
	assign acc_s       = signed'(acc_q[sia_pkg::DATA_W-1:0]);
	assign sum_w       = sia_pkg::WIDE_W'(acc_s) + sia_pkg::WIDE_W'(operand);
	assign zero_div    = acc_s[sia_pkg::DATA_W-1] ? sia_pkg::SAT_LOW : sia_pkg::SAT_HIGH;
	assign quo_s       = neg_q ? signed'(sia_pkg::DATA_W'(0 - div_rsp.quotient))
	                           : signed'(div_rsp.quotient);
	assign div_special = (operand == '0) ||
	                     (acc_s == sia_pkg::INT_MIN && operand == sia_pkg::MINUS_ONE);

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = {{sia_pkg::DATA_W{1'b0}}, sia_pkg::abs32(acc_s)};
		div_req.divisor  = sia_pkg::abs32(operand);
		if (state_q == ST_IDLE) begin
			div_req.start = in_valid && (action == sia_pkg::ACT_DIV) && !div_special;
		end else begin
			div_req.start    = (state_q == ST_PROD) && (act_q == sia_pkg::ACT_FRAC) &&
			                   (den_q != '0);
			div_req.dividend = sia_pkg::abs64(prod_q);
			div_req.divisor  = sia_pkg::abs32(den_q);
		end
	end

	sia_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_OUT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						act_q   <= action;
						den_q   <= denominator;
						prod_q  <= acc_s * operand;
						neg_q   <= acc_s[sia_pkg::DATA_W-1] ^ operand[sia_pkg::DATA_W-1];
						state_q <= ST_OUT;
						case (action) inside
							sia_pkg::ACT_SET: acc_q <= VALUE_WIDTH'(operand);
							sia_pkg::ACT_ADD: acc_q <= VALUE_WIDTH'(sia_pkg::sat64(sum_w));
							sia_pkg::ACT_MUL, sia_pkg::ACT_FRAC: state_q <= ST_PROD;
							sia_pkg::ACT_DIV: begin
								if (operand == '0)
									acc_q <= VALUE_WIDTH'(zero_div);
								else if (div_special)
									acc_q <= VALUE_WIDTH'(sia_pkg::SAT_HIGH);
								else
									state_q <= ST_DIV;
							end
							default: ;
						endcase
					end
				end
				ST_PROD: begin
					state_q <= ST_OUT;
					if (act_q == sia_pkg::ACT_MUL) begin
						acc_q <= VALUE_WIDTH'(sia_pkg::sat64(prod_q));
					end else if (den_q == '0) begin
						acc_q <= VALUE_WIDTH'(zero_div);
					end else begin
						neg_q   <= prod_q[sia_pkg::WIDE_W-1] ^ den_q[sia_pkg::DATA_W-1];
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_OUT;
						if (act_q == sia_pkg::ACT_DIV)
							acc_q <= VALUE_WIDTH'(quo_s);
						else if (div_rsp.ovf || div_rsp.quotient > sia_pkg::SAT_MAG)
							acc_q <= VALUE_WIDTH'(neg_q ? sia_pkg::SAT_LOW : sia_pkg::SAT_HIGH);
						else
							acc_q <= VALUE_WIDTH'(quo_s);
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q       <= acc_s;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign result_value = out_q;

	`SIA_ASSERT(a_acc_ext, clk, arst_n, 1'b1, acc_q == VALUE_WIDTH'(acc_s), "acc upper bits not sign extension")
	`SIA_ASSERT(a_div_done, clk, arst_n, div_rsp.done, state_q == ST_DIV, "divider done outside divide state")
	`SIA_ASSERT_NEXT(a_frac_sat, clk, arst_n, state_q == ST_DIV && div_rsp.done && act_q == sia_pkg::ACT_FRAC, acc_s <= sia_pkg::SAT_HIGH && acc_s >= sia_pkg::SAT_LOW, "frac result out of range")
	`SIA_ASSERT(a_out_rise, clk, arst_n, $rose(out_valid_q), $past(state_q) == ST_OUT, "result shown without completing an item")

endmodule

### tb/saturating_integer_accumulator_core_tb.sv
`timescale 1ns / 100ps

module saturating_integer_accumulator_core_tb;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int PHASE_ITEMS   = 475;
	localparam int DRAIN_CYCLES  = 80;
	localparam logic [sia_pkg::ACT_W-1:0] ACT_LAST = '1;

	class accumulator_scoreboard;
		logic signed [sia_pkg::DATA_W-1:0] acc_value;
		logic signed [sia_pkg::DATA_W-1:0] pending_results[$];
		int errors;
		int transfers;
		int clamped;
		int act_count[8];

		function new();
			acc_value = '0;
			errors = 0;
			transfers = 0;
			clamped = 0;
			foreach (act_count[i])
				act_count[i] = 0;
		endfunction

		function longint clamp_value(longint v);
			if (v > longint'(sia_pkg::SAT_HIGH)) begin
				clamped++;
				return longint'(sia_pkg::SAT_HIGH);
			end
			if (v < longint'(sia_pkg::SAT_LOW)) begin
				clamped++;
				return longint'(sia_pkg::SAT_LOW);
			end
			return v;
		endfunction

		function longint zero_divide_value(longint v);
			clamped++;
			return (v >= 0) ? longint'(sia_pkg::SAT_HIGH) : longint'(sia_pkg::SAT_LOW);
		endfunction

		function void note_input(logic [sia_pkg::ACT_W-1:0] act,
				logic signed [sia_pkg::DATA_W-1:0] opnd,
				logic signed [sia_pkg::DATA_W-1:0] den);
			longint v;
			longint o;
			longint d;
			longint r;
			v = acc_value;
			o = opnd;
			d = den;
			r = v;
			transfers++;
			act_count[act]++;
			case (act)
				sia_pkg::ACT_SET: r = o;
				sia_pkg::ACT_ADD: r = clamp_value(v + o);
				sia_pkg::ACT_MUL: r = clamp_value(v * o);
				sia_pkg::ACT_DIV: begin
					if (o == 0)
						r = zero_divide_value(v);
					else if (acc_value == sia_pkg::INT_MIN && opnd == sia_pkg::MINUS_ONE) begin
						clamped++;
						r = longint'(sia_pkg::SAT_HIGH);
					end else
						r = v / o;
				end
				sia_pkg::ACT_FRAC: begin
					if (d == 0)
						r = zero_divide_value(v);
					else
						r = clamp_value((v * o) / d);
				end
				default: r = v;
			endcase
			acc_value = r[sia_pkg::DATA_W-1:0];
			pending_results.push_back(acc_value);
		endfunction

		function void check_result(logic signed [sia_pkg::DATA_W-1:0] got);
			logic signed [sia_pkg::DATA_W-1:0] exp_value;
			if (pending_results.size() == 0) begin
				errors++;
				$error("result_value: no result pending, got %0d", got);
				return;
			end
			exp_value = pending_results.pop_front();
			if (got !== exp_value) begin
				errors++;
				$error("result_value mismatch: expected %0d, actual %0d", exp_value, got);
			end
		endfunction
	endclass

	logic                               clk;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic [sia_pkg::ACT_W-1:0]          action = '0;
	logic signed [sia_pkg::DATA_W-1:0]  operand = '0;
	logic signed [sia_pkg::DATA_W-1:0]  denominator = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic signed [sia_pkg::DATA_W-1:0]  result_value;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycle_count = 0;

	accumulator_scoreboard sb = new();

	saturating_integer_accumulator_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.operand     (operand),
		.denominator (denominator),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_value(result_value)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// transfer monitor, sampled before this edge's updates land
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_input(action, operand, denominator);
			if (out_valid && out_ready)
				sb.check_result(result_value);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_item(logic [sia_pkg::ACT_W-1:0] act,
			logic signed [sia_pkg::DATA_W-1:0] opnd,
			logic signed [sia_pkg::DATA_W-1:0] den);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		operand     <= opnd;
		denominator <= den;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	function automatic logic signed [sia_pkg::DATA_W-1:0] pick_word();
		logic signed [sia_pkg::DATA_W-1:0] w;
		case ($urandom_range(0, 6))
			0, 1: w = $urandom;
			2: w = $urandom_range(0, 40) - 20;
			3: begin
				case ($urandom_range(0, 7))
					0: w = sia_pkg::INT_MIN;
					1: w = ~sia_pkg::INT_MIN;
					2: w = '0;
					3: w = 1;
					4: w = sia_pkg::MINUS_ONE;
					5: w = sia_pkg::SAT_HIGH;
					6: w = sia_pkg::SAT_LOW;
					default: w = 2;
				endcase
			end
			4: w = sia_pkg::SAT_HIGH + $urandom_range(0, 8) - 4;
			5: w = sia_pkg::SAT_LOW + $urandom_range(0, 8) - 4;
			default: w = $urandom_range(0, 100000) - 50000;
		endcase
		return w;
	endfunction

	function automatic logic [sia_pkg::ACT_W-1:0] pick_action();
		int p;
		p = $urandom_range(99);
		if (p < 15)
			return sia_pkg::ACT_SET;
		if (p < 35)
			return sia_pkg::ACT_ADD;
		if (p < 55)
			return sia_pkg::ACT_MUL;
		if (p < 75)
			return sia_pkg::ACT_DIV;
		if (p < 95)
			return sia_pkg::ACT_FRAC;
		return sia_pkg::ACT_W'($urandom_range(sia_pkg::ACT_FRAC + 1, ACT_LAST));
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners: unclamped set, add/mul clamp, div/frac zero and overflow, unused codes
		send_item(sia_pkg::ACT_SET,  ~sia_pkg::INT_MIN, $urandom);
		send_item(sia_pkg::ACT_ADD,  1, $urandom);
		send_item(sia_pkg::ACT_SET,  sia_pkg::INT_MIN, $urandom);
		send_item(sia_pkg::ACT_ADD,  sia_pkg::INT_MIN, $urandom);
		send_item(sia_pkg::ACT_SET,  sia_pkg::INT_MIN, $urandom);
		send_item(sia_pkg::ACT_DIV,  sia_pkg::MINUS_ONE, $urandom);
		send_item(sia_pkg::ACT_DIV,  '0, $urandom);
		send_item(sia_pkg::ACT_SET,  -5, $urandom);
		send_item(sia_pkg::ACT_DIV,  '0, $urandom);
		send_item(sia_pkg::ACT_SET,  '0, $urandom);
		send_item(sia_pkg::ACT_DIV,  '0, $urandom);
		send_item(sia_pkg::ACT_SET,  -7, $urandom);
		send_item(sia_pkg::ACT_DIV,  2, $urandom);
		send_item(sia_pkg::ACT_SET,  sia_pkg::INT_MIN, $urandom);
		send_item(sia_pkg::ACT_MUL,  sia_pkg::INT_MIN, $urandom);
		send_item(sia_pkg::ACT_SET,  ~sia_pkg::INT_MIN, $urandom);
		send_item(sia_pkg::ACT_MUL,  sia_pkg::INT_MIN, $urandom);
		send_item(sia_pkg::ACT_SET,  sia_pkg::INT_MIN, $urandom);
		send_item(sia_pkg::ACT_FRAC, sia_pkg::INT_MIN, sia_pkg::MINUS_ONE);
		send_item(sia_pkg::ACT_FRAC, 3, '0);
		send_item(sia_pkg::ACT_SET,  -7, $urandom);
		send_item(sia_pkg::ACT_FRAC, 3, 2);
		send_item(sia_pkg::ACT_FRAC, ~sia_pkg::INT_MIN, sia_pkg::INT_MIN);
		send_item(sia_pkg::ACT_W'(sia_pkg::ACT_FRAC + 1), $urandom, $urandom);
		send_item(ACT_LAST, $urandom, $urandom);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_item(pick_action(), pick_word(), pick_word());
		end
		in_valid <= 1'b0;
		recv_stall_pct = 0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d transfers: set %0d, add %0d, mul %0d, div %0d, frac %0d, unused %0d.",
			sb.transfers, sb.act_count[sia_pkg::ACT_SET], sb.act_count[sia_pkg::ACT_ADD],
			sb.act_count[sia_pkg::ACT_MUL], sb.act_count[sia_pkg::ACT_DIV],
			sb.act_count[sia_pkg::ACT_FRAC],
			sb.transfers - sb.act_count[sia_pkg::ACT_SET] - sb.act_count[sia_pkg::ACT_ADD]
				- sb.act_count[sia_pkg::ACT_MUL] - sb.act_count[sia_pkg::ACT_DIV]
				- sb.act_count[sia_pkg::ACT_FRAC]);
		$display("%0d results hit the +-1e9 limit or a zero divisor; %0d mismatches.",
			sb.clamped, sb.errors);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
